>>> src/rlle_pkg.sv
package rlle_pkg;

  localparam int RUN_STORE  = 512;
  localparam int INDEX_SPAN = 140;

  localparam int IDX_W    = 8;
  localparam int LVL_W    = 8;
  localparam int DUR_W    = 15;
  localparam int NUM_W    = 9;
  localparam int EMIT_W   = 10;
  localparam int LIM_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam int GATE_FLOOR_RSSI  = -132;
  localparam int GATE_FLOOR_INDEX = 138;
  localparam logic [DUR_W-1:0] COUNT_CEILING = 15'h7FFF;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_RSSI_OFFSET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUR_LIMIT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_LEVEL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BOUNDARY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RUNS_LIMIT     = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GATE,
    ST_GATE_CHK,
    ST_DIV_LVL,
    ST_LEVEL,
    ST_EMIT
  } rlle_state_e;

  // Level from the quotient of (index - first boundary) / bin width.
  function automatic logic [LVL_W-1:0] quant_level(input logic below,
                                                    input logic [LVL_W-1:0] top,
                                                    input logic [IDX_W-1:0] quo);
    logic [LVL_W:0]   drop;
    logic [LVL_W-1:0] lvl;
    drop = {1'b0, quo} + 9'd1;
    if (below) begin
      lvl = top;
    end else if ({1'b0, top} > drop) begin
      lvl = top - drop[LVL_W-1:0];
    end else begin
      lvl = '0;
    end
    return (lvl == '0) ? LVL_W'(1) : lvl;
  endfunction

endpackage

>>> src/rlle_in_if.sv
interface rlle_in_if;
  logic              valid;
  logic              ready;
  logic              command;
  logic signed [7:0] rssi_sample;

  modport source (output valid, output command, output rssi_sample, input ready);
  modport sink   (input valid, input command, input rssi_sample, output ready);
endinterface

>>> src/rlle_out_if.sv
interface rlle_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  run_level;
  logic [14:0] run_duration;
  logic [8:0]  run_number;
  logic        last_run;

  modport source (output valid, output run_level, output run_duration,
                  output run_number, output last_run, input ready);
  modport sink   (input valid, input run_level, input run_duration,
                  input run_number, input last_run, output ready);
endinterface

>>> src/rssi_level_run_length_encoder.sv
// Channel   Direction  Payload
// in_ch     sink       command, rssi_sample
// out_ch    source     run_level, run_duration, run_number, last_run
// cfg       write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// A sample goes through the eight-step shared divider for its gate index and again for
// its level index when they differ; one that closes a run then goes to the emit state.
// No new sample is taken before the last is done. A sample that fails the gate stops
// at the gate check; a finish emits any open run; input after the window is dropped.
// A result leaves through an output register; the block waits only when it holds a
// new result and that register has not yet been emptied.
// Reset restores the register defaults and starts a new window with no run open.
module rssi_level_run_length_encoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  rlle_in_if.sink                             in_ch,
  rlle_out_if.source                          out_ch,
  input  logic                                cfg_we_i,
  input  logic [rlle_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rlle_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int IW = rlle_pkg::IDX_W;
  localparam int LW = rlle_pkg::LVL_W;
  localparam int DW = rlle_pkg::DUR_W;
  localparam int NW = rlle_pkg::NUM_W;
  localparam int EW = rlle_pkg::EMIT_W;
  localparam int MW = rlle_pkg::LIM_W;
  localparam int CW = $clog2(IW);

  logic [6:0]    rssi_offset_q;
  logic [7:0]    gate_threshold_q;
  logic [DW-1:0] dur_limit_q;
  logic [LW-1:0] top_level_q;
  logic [IW-1:0] first_boundary_q;
  logic [7:0]    bin_width_q;
  logic [9:0]    runs_limit_q;

  rlle_pkg::rlle_state_e state_q, state_d;

  logic [LW-1:0] open_level_q, open_level_d;
  logic [DW-1:0] open_count_q, open_count_d;
  logic          run_open_q, run_open_d;
  logic [EW-1:0] runs_emitted_q, runs_emitted_d;
  logic          window_done_q, window_done_d;

  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] gidx_q, gidx_d;
  logic          below_q, below_d;
  logic [IW-1:0] quo_q, quo_d;
  logic [7:0]    rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic [LW-1:0] res_level_q, res_level_d;
  logic [DW-1:0] res_dur_q, res_dur_d;
  logic [NW-1:0] res_num_q, res_num_d;
  logic          res_last_q, res_last_d;

  logic          out_valid_q, out_valid_d;
  logic [LW-1:0] out_level_q, out_level_d;
  logic [DW-1:0] out_dur_q, out_dur_d;
  logic [NW-1:0] out_num_q, out_num_d;
  logic          out_last_q, out_last_d;

  logic signed [9:0] v_c;
  logic signed [9:0] neg_c;
  logic [IW-1:0]     idx_c;
  logic [IW-1:0]     gidx_c;
  logic [7:0]        bw_c;
  logic [8:0]        shift_c;
  logic              ge_c;
  logic [LW-1:0]     level_c;
  logic [MW-1:0]     limit_c;
  logic              last_c;
  logic              close_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rssi_offset_q    <= 7'd45;
      gate_threshold_q <= 8'd1;
      dur_limit_q      <= 15'd1000;
      top_level_q      <= 8'd20;
      first_boundary_q <= 8'd64;
      bin_width_q      <= 8'd4;
      runs_limit_q     <= 10'd512;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rlle_pkg::CFG_RSSI_OFFSET:    rssi_offset_q    <= cfg_data_i[6:0];
        rlle_pkg::CFG_GATE_THRESHOLD: gate_threshold_q <= cfg_data_i[7:0];
        rlle_pkg::CFG_DUR_LIMIT:      dur_limit_q      <= cfg_data_i[DW-1:0];
        rlle_pkg::CFG_TOP_LEVEL:      top_level_q      <= cfg_data_i[LW-1:0];
        rlle_pkg::CFG_FIRST_BOUNDARY: first_boundary_q <= cfg_data_i[IW-1:0];
        rlle_pkg::CFG_BIN_WIDTH:      bin_width_q      <= cfg_data_i[7:0];
        rlle_pkg::CFG_RUNS_LIMIT:     runs_limit_q     <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Table index is minus the offset sample, minus one, clamped to the table.
  always_comb begin
    v_c   = {{2{in_ch.rssi_sample[7]}}, in_ch.rssi_sample} - {3'b000, rssi_offset_q};
    neg_c = ~v_c;
    if (neg_c < 0) begin
      idx_c = '0;
    end else if (int'(neg_c) > rlle_pkg::INDEX_SPAN - 1) begin
      idx_c = IW'(rlle_pkg::INDEX_SPAN - 1);
    end else begin
      idx_c = neg_c[IW-1:0];
    end
    gidx_c = (int'(v_c) <= rlle_pkg::GATE_FLOOR_RSSI) ?
             IW'(rlle_pkg::GATE_FLOOR_INDEX) : idx_c;
  end

  assign bw_c    = (bin_width_q == '0) ? 8'd1 : bin_width_q;
  assign shift_c = {rem_q, quo_q[IW-1]};
  assign ge_c    = shift_c >= {1'b0, bw_c};
  assign level_c = rlle_pkg::quant_level(below_q, top_level_q, quo_q);

  always_comb begin
    if (runs_limit_q == '0) begin
      limit_c = MW'(1);
    end else if ({3'b000, runs_limit_q} > MW'(rlle_pkg::RUN_STORE)) begin
      limit_c = MW'(rlle_pkg::RUN_STORE);
    end else begin
      limit_c = {3'b000, runs_limit_q};
    end
  end

  assign last_c  = ({3'b000, runs_emitted_q} + MW'(1)) >= limit_c;
  assign close_c = (level_c != open_level_q) || (open_count_q >= dur_limit_q) ||
                   (open_count_q == rlle_pkg::COUNT_CEILING);

  always_comb begin
    state_d        = state_q;
    open_level_d   = open_level_q;
    open_count_d   = open_count_q;
    run_open_d     = run_open_q;
    runs_emitted_d = runs_emitted_q;
    window_done_d  = window_done_q;
    idx_d          = idx_q;
    gidx_d         = gidx_q;
    below_d        = below_q;
    quo_d          = quo_q;
    rem_d          = rem_q;
    cnt_d          = cnt_q;
    res_level_d    = res_level_q;
    res_dur_d      = res_dur_q;
    res_num_d      = res_num_q;
    res_last_d     = res_last_q;
    out_valid_d    = out_valid_q && !out_ch.ready;
    out_level_d    = out_level_q;
    out_dur_d      = out_dur_q;
    out_num_d      = out_num_q;
    out_last_d     = out_last_q;

    case (state_q)
      rlle_pkg::ST_IDLE: begin
        if (in_ch.valid && !window_done_q) begin
          if (in_ch.command == rlle_pkg::CMD_FINISH) begin
            window_done_d = 1'b1;
            if (run_open_q) begin
              res_level_d    = open_level_q;
              res_dur_d      = open_count_q;
              res_num_d      = runs_emitted_q[NW-1:0];
              res_last_d     = 1'b1;
              runs_emitted_d = runs_emitted_q + EW'(1);
              run_open_d     = 1'b0;
              state_d        = rlle_pkg::ST_EMIT;
            end
          end else begin
            idx_d   = idx_c;
            gidx_d  = gidx_c;
            below_d = gidx_c < first_boundary_q;
            quo_d   = gidx_c - first_boundary_q;
            rem_d   = '0;
            cnt_d   = '0;
            state_d = rlle_pkg::ST_DIV_GATE;
          end
        end
      end
      rlle_pkg::ST_DIV_GATE, rlle_pkg::ST_DIV_LVL: begin
        rem_d = ge_c ? 8'(shift_c - {1'b0, bw_c}) : shift_c[7:0];
        quo_d = {quo_q[IW-2:0], ge_c};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(IW - 1)) begin
          state_d = (state_q == rlle_pkg::ST_DIV_GATE) ?
                    rlle_pkg::ST_GATE_CHK : rlle_pkg::ST_LEVEL;
        end
      end
      rlle_pkg::ST_GATE_CHK: begin
        if (level_c <= gate_threshold_q) begin
          state_d = rlle_pkg::ST_IDLE;
        end else if (idx_q == gidx_q) begin
          state_d = rlle_pkg::ST_LEVEL;
        end else begin
          below_d = idx_q < first_boundary_q;
          quo_d   = idx_q - first_boundary_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = rlle_pkg::ST_DIV_LVL;
        end
      end
      rlle_pkg::ST_LEVEL: begin
        state_d = rlle_pkg::ST_IDLE;
        if (!run_open_q) begin
          open_level_d = level_c;
          open_count_d = DW'(1);
          run_open_d   = 1'b1;
        end else if (close_c) begin
          res_level_d    = open_level_q;
          res_dur_d      = open_count_q;
          res_num_d      = runs_emitted_q[NW-1:0];
          res_last_d     = last_c;
          runs_emitted_d = runs_emitted_q + EW'(1);
          if (last_c) begin
            window_done_d = 1'b1;
            run_open_d    = 1'b0;
          end else begin
            open_level_d = level_c;
            open_count_d = DW'(1);
          end
          state_d = rlle_pkg::ST_EMIT;
        end else begin
          open_count_d = open_count_q + DW'(1);
        end
      end
      rlle_pkg::ST_EMIT: begin
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d = 1'b1;
          out_level_d = res_level_q;
          out_dur_d   = res_dur_q;
          out_num_d   = res_num_q;
          out_last_d  = res_last_q;
          state_d     = rlle_pkg::ST_IDLE;
        end
      end
      default: state_d = rlle_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= rlle_pkg::ST_IDLE;
      open_level_q   <= '0;
      open_count_q   <= '0;
      run_open_q     <= 1'b0;
      runs_emitted_q <= '0;
      window_done_q  <= 1'b0;
      cnt_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      open_level_q   <= open_level_d;
      open_count_q   <= open_count_d;
      run_open_q     <= run_open_d;
      runs_emitted_q <= runs_emitted_d;
      window_done_q  <= window_done_d;
      cnt_q          <= cnt_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    gidx_q      <= gidx_d;
    below_q     <= below_d;
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    res_level_q <= res_level_d;
    res_dur_q   <= res_dur_d;
    res_num_q   <= res_num_d;
    res_last_q  <= res_last_d;
    out_level_q <= out_level_d;
    out_dur_q   <= out_dur_d;
    out_num_q   <= out_num_d;
    out_last_q  <= out_last_d;
  end

  assign in_ch.ready         = (state_q == rlle_pkg::ST_IDLE);
  assign out_ch.valid        = out_valid_q;
  assign out_ch.run_level    = out_level_q;
  assign out_ch.run_duration = out_dur_q;
  assign out_ch.run_number   = out_num_q;
  assign out_ch.last_run     = out_last_q;

  // Once the window has ended it stays ended until reset.
  a_window_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    window_done_q |=> window_done_q)
    else $error("window reopened without reset");

  // A run marked last can only be presented after the window has ended.
  a_last_ends_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> window_done_q)
    else $error("last run presented while the window is still open");

  // An open run always holds at least one sample and a level of at least one.
  a_open_run_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_open_q |-> (open_count_q != '0 && open_level_q != '0))
    else $error("open run with zero count or level");

  // No run stays open once the window has ended.
  a_done_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    window_done_q |-> !run_open_q)
    else $error("run open after the window ended");

endmodule
